>>> src/sorted_set_table_assert.svh
// ----------------------------------------------------------------------------
// sorted_set_table_assert.svh
// assertion macros for the sorted set table checker
// ----------------------------------------------------------------------------
`ifndef SORTED_SET_TABLE_ASSERT_SVH
`define SORTED_SET_TABLE_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge outside reset
`define SST_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted_set_table check failed");

// next-cycle implication
`define SST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted_set_table check failed");

`endif

>>> src/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg
// shared types and codes of the sorted set table
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int WORD_W = 32;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // command broadcast to every cell in the execute cycle
  typedef struct packed {
    logic  ins;
    logic  rem;
    word_t key;
  } cell_cmd_t;

  // compare results a cell reports back
  typedef struct packed {
    logic lt;
    logic eq;
  } cell_flags_t;

endpackage

>>> src/sst_cell.sv
// ----------------------------------------------------------------------------
// sst_cell
// one slot of the sorted row: compares its member with the key and
// shifts right on insert or left on remove
// ----------------------------------------------------------------------------
module sst_cell (
  input  logic                clk,
  input  logic                occupied,
  input  sst_pkg::cell_cmd_t  cmd,
  input  sst_pkg::cell_flags_t left_flags,
  input  sst_pkg::word_t      left_word,
  input  sst_pkg::word_t      right_word,
  output sst_pkg::cell_flags_t flags,
  output sst_pkg::word_t      word
);
  import sst_pkg::*;

  word_t word_r;
  word_t word_nxt;

  assign flags.lt = occupied && (word_r < cmd.key);
  assign flags.eq = occupied && (word_r == cmd.key);
  assign word     = word_r;

  always_comb begin
    word_nxt = word_r;
    if (cmd.ins && !flags.lt) begin
      word_nxt = left_flags.lt ? cmd.key : left_word;
    end else if (cmd.rem && !flags.lt) begin
      word_nxt = right_word;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

endmodule

>>> src/sorted_set_table.sv
// ----------------------------------------------------------------------------
// sorted_set_table
// set of distinct signed 32-bit words kept in ascending order
// ----------------------------------------------------------------------------
// in_ channel takes one word (operation, value, index); out_ channel returns
// one word per input word (was_member, status, size_now, element).
// operations: add (duplicates ignored, refused when full), remove,
// membership query, and read of the member at a sorted index.
// the members sit in a row of CAPACITY cells; every cell compares its member
// with the key in parallel and, on add or remove, takes its neighbor's
// member, so all cells of the row shift in the same cycle.
// an accepted word is captured into registers, then executed in S_EXEC
// (the row update step) once the result register is free; its result is
// registered onto out_. a new word is taken only in S_IDLE, after the last one has executed.
// the result register frees the input side: a new word is accepted while a
// result still waits, but it is not executed until that result is taken.
// reset empties the set at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_set_table #(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_operation,
  input  sst_pkg::word_t      in_value,
  input  logic [5:0]          in_index,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_was_member,
  output logic [1:0]          out_status,
  output logic [6:0]          out_size_now,
  output sst_pkg::word_t      out_element
);
  import sst_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t           state_r;
  logic [1:0]       op_r;
  word_t            key_r;
  logic [5:0]       idx_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  logic             out_valid_r;
  logic             was_member_r;
  logic [1:0]       status_r;
  logic [6:0]       size_r;
  word_t            element_r;

  cell_cmd_t        cmd;
  cell_flags_t      flags   [CAPACITY];
  word_t            words   [CAPACITY];
  logic [CAPACITY-1:0] eq_vec;

  logic             present;
  logic             is_full;
  logic             do_ins;
  logic             do_rem;
  logic             rd_ok;
  logic [1:0]       status_nxt;
  word_t            element_nxt;
  logic             exec_go;

  assign in_ready = (state_r == S_IDLE);
  assign exec_go  = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  assign present = |eq_vec;
  assign is_full = (count_r == CNT_W'(CAPACITY));
  assign do_ins  = exec_go && (op_r == OP_ADD) && !present && !is_full;
  assign do_rem  = exec_go && (op_r == OP_REMOVE) && present;
  assign rd_ok   = (32'(idx_r) < 32'(count_r));

  assign cmd.ins = do_ins;
  assign cmd.rem = do_rem;
  assign cmd.key = key_r;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      cell_flags_t left_flags;
      word_t       left_word;
      word_t       right_word;

      if (gi == 0) begin : g_first
        assign left_flags = '{lt: 1'b1, eq: 1'b0};
        assign left_word  = key_r;
      end else begin : g_mid
        assign left_flags = flags[gi-1];
        assign left_word  = words[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_last
        assign right_word = words[gi];
      end else begin : g_inner
        assign right_word = words[gi+1];
      end

      sst_cell u_cell (
        .clk        (clk),
        .occupied   (CNT_W'(gi) < count_r),
        .cmd        (cmd),
        .left_flags (left_flags),
        .left_word  (left_word),
        .right_word (right_word),
        .flags      (flags[gi]),
        .word       (words[gi])
      );

      assign eq_vec[gi] = flags[gi].eq;
    end
  endgenerate

  always_comb begin
    element_nxt = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (32'(idx_r) == i) begin
        element_nxt = element_nxt | words[i];
      end
    end
    if (op_r != OP_READ || !rd_ok) begin
      element_nxt = '0;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (do_ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_rem) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    status_nxt = ST_DONE;
    unique case (op_r)
      OP_ADD:    if (!present && is_full) status_nxt = ST_FULL;
      OP_READ:   if (!rd_ok) status_nxt = ST_RANGE;
      default:   status_nxt = ST_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (exec_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= in_operation;
            key_r   <= in_value;
            idx_r   <= in_index;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            count_r      <= count_nxt;
            was_member_r <= present;
            status_r     <= status_nxt;
            size_r       <= 7'(count_nxt);
            element_r    <= element_nxt;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_was_member = was_member_r;
  assign out_status     = status_r;
  assign out_size_now   = size_r;
  assign out_element    = element_r;

endmodule

>>> src/sst_checker.sv
// ----------------------------------------------------------------------------
// sst_checker
// port-level checks of the sorted set table, bound to the top level
// ----------------------------------------------------------------------------
`include "sorted_set_table_assert.svh"

module sst_checker #(
  parameter int CAPACITY = 64
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic                out_was_member,
  input logic [1:0]          out_status,
  input logic [6:0]          out_size_now,
  input sst_pkg::word_t      out_element
);
  import sst_pkg::*;

  `SST_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_size_now))
  `SST_ASSERT_NEXT(a_in_gap, in_valid && in_ready, !in_ready)
  `SST_ASSERT_IMPLY(a_full_size, out_valid && out_status == ST_FULL,
                    !out_was_member && out_size_now == 7'(CAPACITY))
  `SST_ASSERT_IMPLY(a_range_zero, out_valid && out_status == ST_RANGE, out_element == '0)
  `SST_ASSERT_IMPLY(a_status_code, out_valid,
                    out_status == ST_DONE || out_status == ST_FULL || out_status == ST_RANGE)

endmodule

bind sorted_set_table sst_checker #(.CAPACITY(CAPACITY)) u_sst_checker (.*);

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the sorted set table
// ----------------------------------------------------------------------------
// a queue of pending words feeds a clocked driver on the in_ channel; a
// clocked monitor predicts each accepted word against its own copy of the
// ordered member list and checks every out_ word field by field, in order.
// stimulus: a directed opening on the empty and small set, then three rounds
// of fill to capacity, mixed traffic and shrink, each round with a different
// pattern of sender and receiver idling, plus one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
  import sst_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY    = 64;
  localparam int POOL_SIZE   = 96;
  localparam int HOLD_CYCLES = 300;
  localparam int END_TAIL    = 16;
  localparam int CYCLE_LIMIT = 200000;

  localparam word_t W_MIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam word_t W_MAX = {1'b0, {(WORD_W-1){1'b1}}};

  typedef struct {
    op_t        op;
    word_t      value;
    logic [5:0] index;
  } set_cmd_t;

  typedef struct {
    logic       was_member;
    logic [1:0] status;
    logic [6:0] size_now;
    word_t      element;
  } set_reply_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_operation = OP_QUERY;
  word_t      in_value = '0;
  logic [5:0] in_index = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_was_member;
  logic [1:0] out_status;
  logic [6:0] out_size_now;
  word_t      out_element;

  set_cmd_t   pending_cmds[$];
  set_reply_t expected_replies[$];

  word_t members [CAPACITY];
  int    member_total = 0;
  word_t value_pool [POOL_SIZE];

  int   words_queued = 0;
  int   words_taken = 0;
  int   replies_checked = 0;
  int   err_count = 0;
  int   cycle_count = 0;
  int   send_idle_pct = 34;
  int   recv_idle_pct = 64;
  logic in_taken = 1'b0;
  logic hold_arm = 1'b0;
  logic recv_hold = 1'b0;

  sorted_set_table #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_value      (in_value),
    .in_index      (in_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_was_member(out_was_member),
    .out_status    (out_status),
    .out_size_now  (out_size_now),
    .out_element   (out_element)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ordered set update for one accepted word
  function automatic set_reply_t apply_set_cmd(input set_cmd_t c);
    set_reply_t r;
    int         pos;
    int         i;
    logic       present;
    pos = 0;
    while (pos < member_total && members[pos] < c.value) pos++;
    present = (pos < member_total) && (members[pos] == c.value);
    r.was_member = present;
    r.status = ST_DONE;
    r.element = '0;
    case (c.op)
      OP_ADD: begin
        if (!present) begin
          if (member_total >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            for (i = member_total; i > pos; i--) members[i] = members[i-1];
            members[pos] = c.value;
            member_total++;
          end
        end
      end
      OP_REMOVE: begin
        if (present) begin
          for (i = pos; i + 1 < member_total; i++) members[i] = members[i+1];
          member_total--;
        end
      end
      OP_READ: begin
        if (int'(c.index) < member_total) r.element = members[c.index];
        else r.status = ST_RANGE;
      end
      default: ;
    endcase
    r.size_now = member_total[6:0];
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      err_count++;
      $display("%0t: %s mismatch, expected 0x%h, actual 0x%h", $time, name, exp_v, got_v);
    end
  endfunction

  // driver
  always @(negedge clk) begin
    set_cmd_t c;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        c = pending_cmds.pop_front();
        in_valid <= 1'b1;
        in_operation <= c.op;
        in_value <= c.value;
        in_index <= c.index;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    out_ready <= rst_n && !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor
  always @(posedge clk) begin
    set_cmd_t   c;
    set_reply_t e;
    in_taken = rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      if (expected_replies.size() == 0) begin
        err_count++;
        $display("%0t: unexpected out word, actual size_now %0d status %0d", $time,
                 out_size_now, out_status);
      end else begin
        e = expected_replies.pop_front();
        check_field("was_member", 32'(e.was_member), 32'(out_was_member));
        check_field("status", 32'(e.status), 32'(out_status));
        check_field("size_now", 32'(e.size_now), 32'(out_size_now));
        check_field("element", e.element, out_element);
        replies_checked++;
      end
    end
    if (in_taken) begin
      c.op = op_t'(in_operation);
      c.value = in_value;
      c.index = in_index;
      expected_replies.push_back(apply_set_cmd(c));
      words_taken++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sorted_set_table verification failed");
      $finish;
    end
  end

  // long receiver hold-off so the table backs up and stalls in_
  initial begin
    wait (hold_arm);
    @(posedge clk);
    recv_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    recv_hold = 1'b0;
  end

  task automatic queue_cmd(input op_t op, input word_t v, input logic [5:0] idx);
    set_cmd_t c;
    c.op = op;
    c.value = v;
    c.index = idx;
    pending_cmds.push_back(c);
    words_queued++;
  endtask

  task automatic wait_drained();
    while (replies_checked != words_queued) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    int round;
    int k;
    int start;
    value_pool[0] = W_MIN;
    value_pool[1] = W_MAX;
    value_pool[2] = '0;
    value_pool[3] = -1;
    value_pool[4] = 1;
    value_pool[5] = W_MIN + 1;
    value_pool[6] = W_MAX - 1;
    for (k = 7; k < POOL_SIZE; k++) value_pool[k] = $urandom;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty set, extremes, duplicates, absent removes, reads past the count
    queue_cmd(OP_QUERY, '0, 6'd0);
    queue_cmd(OP_READ, '0, 6'd0);
    queue_cmd(OP_READ, W_MAX, 6'd63);
    queue_cmd(OP_REMOVE, 32'sd5, 6'd0);
    queue_cmd(OP_ADD, W_MAX, 6'd63);
    queue_cmd(OP_ADD, W_MIN, 6'd0);
    queue_cmd(OP_ADD, '0, 6'd21);
    queue_cmd(OP_ADD, -1, 6'd42);
    queue_cmd(OP_ADD, 32'sd1, 6'd0);
    queue_cmd(OP_ADD, '0, 6'd0);
    queue_cmd(OP_READ, W_MAX, 6'd0);
    queue_cmd(OP_READ, '0, 6'd4);
    queue_cmd(OP_READ, W_MIN, 6'd5);
    queue_cmd(OP_QUERY, W_MIN, 6'd63);
    queue_cmd(OP_QUERY, 32'sd7, 6'd0);
    queue_cmd(OP_REMOVE, 32'sd1, 6'd0);
    queue_cmd(OP_REMOVE, 32'sd1, 6'd0);
    queue_cmd(OP_REMOVE, W_MAX, 6'd0);
    queue_cmd(OP_REMOVE, W_MIN, 6'd0);
    queue_cmd(OP_READ, '0, 6'd0);
    queue_cmd(OP_READ, '0, 6'd2);
    wait_drained();

    for (round = 0; round < 3; round++) begin
      send_idle_pct = (round == 0) ? 34 : (round == 1) ? 64 : 0;
      recv_idle_pct = (round == 0) ? 64 : (round == 1) ? 34 : 0;

      // fill past capacity so adds get refused
      start = $urandom_range(POOL_SIZE - 1);
      for (k = 0; k < 72; k++) begin
        queue_cmd(OP_ADD, value_pool[(start + k) % POOL_SIZE], 6'($urandom_range(63)));
      end
      wait_drained();

      if (round == 0) hold_arm = 1'b1;
      for (k = 0; k < 70; k++) begin
        queue_cmd(op_t'($urandom_range(3)),
                  ($urandom_range(99) < 80) ? value_pool[$urandom_range(POOL_SIZE - 1)]
                                            : word_t'($urandom),
                  6'($urandom_range(63)));
      end
      wait_drained();

      for (k = 0; k < 40; k++) begin
        queue_cmd(OP_REMOVE, value_pool[$urandom_range(POOL_SIZE - 1)],
                  6'($urandom_range(63)));
      end
      wait_drained();
    end

    repeat (END_TAIL) @(posedge clk);
    if (err_count == 0 && expected_replies.size() == 0) begin
      $display("sorted_set_table verification clean");
    end else begin
      $display("sorted_set_table verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/sst_pkg.sv
src/sst_cell.sv
src/sorted_set_table.sv
src/sst_checker.sv
tb/sv/tb.sv
